// File: hw/rtl/positional_list_insert_delete_defines.svh
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTH

// The expression must hold at every clock edge outside reset.
`define PLID_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PLID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define PLID_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define PLID_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/plid_pkg.sv
`timescale 1ns / 1ps

package plid_pkg;

    localparam int VALUE_W = 64;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] entry_value;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
    } t_cell_cmd;

endpackage

// File: hw/rtl/plid_cell.sv
`timescale 1ns / 1ps

module plid_cell #(
    parameter int ENTRY_WIDTH = 64,
    parameter int INDEX       = 0,
    parameter int IDX_W       = 7
) (
    input  logic                    i_clk,
    input  plid_pkg::t_cell_cmd     i_cmd,
    input  logic [ENTRY_WIDTH-1:0]  i_new,
    input  logic [ENTRY_WIDTH-1:0]  i_left,
    input  logic [ENTRY_WIDTH-1:0]  i_right,
    output logic [ENTRY_WIDTH-1:0]  o_data,
    output logic [ENTRY_WIDTH-1:0]  o_tap
);

    localparam int CW = ((IDX_W > plid_pkg::POS_W) ? IDX_W : plid_pkg::POS_W) + 1;
    localparam logic [CW-1:0] IDX0 = CW'(INDEX);
    localparam logic [CW-1:0] IDX1 = CW'(INDEX + 1);

    logic [ENTRY_WIDTH-1:0] r_data;
    logic [ENTRY_WIDTH-1:0] n_data;
    logic [CW-1:0]          pos_e;
    logic                   here;
    logic                   past;
    logic                   at_or_past;

    always_comb begin
        pos_e      = CW'(i_cmd.pos);
        here       = (IDX1 == pos_e);
        past       = (IDX0 >= pos_e);
        at_or_past = (IDX1 >= pos_e);
        n_data     = r_data;
        if (i_cmd.ins) begin
            if (here) begin
                n_data = i_new;
            end else if (past) begin
                n_data = i_left;
            end
        end else if (i_cmd.del && at_or_past) begin
            n_data = i_right;
        end
        o_tap = (i_cmd.del && here) ? r_data : '0;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: hw/rtl/positional_list_insert_delete.sv
`timescale 1ns / 1ps
// Positional list: an ordered list of up to DEPTH entries held in a row of cells.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one operation:
// insert entry_value at a one-based position, or delete the entry at a position.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries one result per
// operation: status, the removed entry (zero unless a delete succeeds) and the
// entry count after the operation.
// The result is valid in the cycle after the input transfer. Throughput is one
// operation per cycle: every cell compares its index with the position and loads
// from its left neighbor, its right neighbor or the new entry in the same cycle.
// The result sits in an output register; a new operation is taken whenever that
// register is empty or is being drained in the same cycle. While the receiver
// stalls with a result pending, o_in_ready is low and the list holds.
// Reset clears the count and the output valid; the cell contents are not reset
// and are only read below the count.

`include "positional_list_insert_delete_defines.svh"

module positional_list_insert_delete #(
    parameter int DEPTH       = 128,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  plid_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output plid_pkg::t_out o_out_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > plid_pkg::POS_W) ? CNT_W : plid_pkg::POS_W) + 1;
    localparam logic [CMP_W-1:0] DEPTH_E = CMP_W'(DEPTH);

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    plid_pkg::t_out         r_out;
    plid_pkg::t_out         n_out;
    logic                   fire;
    plid_pkg::t_status      status;
    plid_pkg::t_cell_cmd    cmd;
    logic [CMP_W-1:0]       pos_e;
    logic [CMP_W-1:0]       cnt_e;
    logic [CMP_W-1:0]       cnt_next_e;
    logic [plid_pkg::COUNT_W-1:0] cnt_low;
    logic [ENTRY_WIDTH-1:0] new_value;
    logic [ENTRY_WIDTH-1:0] removed;
    logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];
    logic [ENTRY_WIDTH-1:0] cell_tap  [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;
    assign new_value  = i_in_data.entry_value[ENTRY_WIDTH-1:0];

    always_comb begin
        pos_e  = CMP_W'(i_in_data.position);
        cnt_e  = CMP_W'(r_count);
        status = plid_pkg::ST_OK;
        if (i_in_data.kind == plid_pkg::KIND_INSERT) begin
            if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1)) begin
                status = plid_pkg::ST_BAD_POS;
            end else if (cnt_e == DEPTH_E) begin
                status = plid_pkg::ST_FULL;
            end
        end else begin
            if (pos_e == '0 || pos_e > cnt_e) begin
                status = plid_pkg::ST_BAD_POS;
            end
        end

        cmd.pos = i_in_data.position;
        cmd.ins = fire && (i_in_data.kind == plid_pkg::KIND_INSERT)
                  && (status == plid_pkg::ST_OK);
        cmd.del = fire && (i_in_data.kind == plid_pkg::KIND_DELETE)
                  && (status == plid_pkg::ST_OK);

        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign cnt_low = cnt_e[plid_pkg::COUNT_W-1:0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] left;
        logic [ENTRY_WIDTH-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_left
            assign left = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_right
            assign right = cell_data[g+1];
        end

        plid_cell #(
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .INDEX       (g),
            .IDX_W       (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_new   (new_value),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g]),
            .o_tap   (cell_tap[g])
        );
    end

    always_comb begin
        removed = '0;
        for (int i = 0; i < DEPTH; i++) begin
            removed = removed | cell_tap[i];
        end
        cnt_next_e          = CMP_W'(n_count);
        n_out.status        = status;
        n_out.removed_value = plid_pkg::VALUE_W'(removed);
        n_out.entry_count   = cnt_next_e[plid_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PLID_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, CMP_W'(r_count) <= DEPTH_E)
    `PLID_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, fire, o_out_valid)
    `PLID_ASSERT_NEXT(a_count_holds_idle, i_clk, i_rst_n, !fire, $stable(r_count))
    `PLID_ASSERT_NEXT(a_result_count, i_clk, i_rst_n, fire, o_out_data.entry_count == cnt_low)

endmodule
